/* hw/rtl/fnt_pkg.sv */
// Shared types, constants and state codes for the face normal and tangent block.
// No dependencies.
package fnt_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [19:0] tex_u;
    logic signed [19:0] tex_v;
  } corner_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               normal_valid;
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic               tangent_valid;
  } result_t;

  // Edge set of one complete triangle, handed from front to back.
  typedef struct packed {
    logic signed [32:0] e1x, e1y, e1z;
    logic signed [32:0] e2x, e2y, e2z;
    logic signed [20:0] d1u, d1v, d2u, d2v;
  } tri_t;

  localparam int QUEUE_DEPTH = 2;
  localparam logic [63:0] ONE_Q14 = 64'd16384;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RED, ST_CR_A, ST_CR_B, ST_CR_C, ST_DET_A, ST_DET_B,
    ST_TG_A, ST_TG_B, ST_TG_C,
    ST_U_LOAD, ST_U_NORM, ST_U_SQ0, ST_U_SQ1, ST_U_SQ2, ST_U_SQRT,
    ST_U_DIV, ST_U_NEXT, ST_OUT
  } back_state_t;

endpackage

/* hw/rtl/fnt_front.sv */
// Front part: counts corners, holds the first two and forms the edge set.
// Depends on fnt_pkg.
module fnt_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  fnt_pkg::corner_t in_data,
  output logic            tri_valid,
  input  logic            tri_ready,
  output fnt_pkg::tri_t   tri_data
);

  logic [1:0] corner_count;
  fnt_pkg::corner_t c0, c1;

  assign in_ready = (corner_count != 2'd2) || tri_ready;
  assign tri_valid = in_valid && (corner_count == 2'd2);

  // Form edges from the held corners and the incoming third one
  always_comb begin
    tri_data.e1x = 33'(c1.pos_x) - 33'(c0.pos_x);
    tri_data.e1y = 33'(c1.pos_y) - 33'(c0.pos_y);
    tri_data.e1z = 33'(c1.pos_z) - 33'(c0.pos_z);
    tri_data.e2x = 33'(in_data.pos_x) - 33'(c0.pos_x);
    tri_data.e2y = 33'(in_data.pos_y) - 33'(c0.pos_y);
    tri_data.e2z = 33'(in_data.pos_z) - 33'(c0.pos_z);
    tri_data.d1u = 21'(c1.tex_u) - 21'(c0.tex_u);
    tri_data.d1v = 21'(c1.tex_v) - 21'(c0.tex_v);
    tri_data.d2u = 21'(in_data.tex_u) - 21'(c0.tex_u);
    tri_data.d2v = 21'(in_data.tex_v) - 21'(c0.tex_v);
  end

  // Advance the corner count and hold corners
  always_ff @(posedge clk) begin
    if (rst) begin
      corner_count <= 2'd0;
    end else if (in_valid && in_ready) begin
      case (corner_count)
        2'd1: begin
          corner_count <= 2'd2;
          c1 <= in_data;
        end
        2'd2: corner_count <= 2'd0;
        default: begin
          corner_count <= 2'd1;
          c0 <= in_data;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/fnt_queue.sv */
// Short queue of edge sets between front and back.
// Depends on fnt_pkg.
module fnt_queue #(
  parameter int DEPTH = fnt_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  fnt_pkg::tri_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output fnt_pkg::tri_t rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  fnt_pkg::tri_t mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   count;

  assign wr_ready = count != (AW+1)'(DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = mem[rp];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (wr_valid && wr_ready) begin
        wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      end
      if (rd_valid && rd_ready) begin
        rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      end
      count <= count + (AW+1)'(wr_valid && wr_ready) - (AW+1)'(rd_valid && rd_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) begin
      mem[wp] <= wr_data;
    end
  end

endmodule

/* hw/rtl/fnt_back.sv */
// Back part: cross product, tangent, and a shared sequential unit-length scaler.
// Depends on fnt_pkg.
module fnt_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              tri_valid,
  output logic              tri_ready,
  input  fnt_pkg::tri_t     tri_data,
  output logic              out_valid,
  input  logic              out_ready,
  output fnt_pkg::result_t  out_data
);

  fnt_pkg::back_state_t state, state_next;
  fnt_pkg::tri_t t;
  logic signed [32:0] r1 [3];
  logic signed [32:0] r2 [3];
  logic signed [63:0] pa [3];
  logic signed [63:0] pb [3];
  logic signed [63:0] cr [3];
  logic signed [63:0] tg [3];
  logic signed [41:0] det;
  logic signed [41:0] dpa;
  logic        which;      // 0 = normal, 1 = tangent
  logic [63:0] m [3];
  logic [63:0] sq [3];
  logic [63:0] rem, root, bitv;
  logic [63:0] num, quo, dsor;
  logic [6:0]  dcnt;
  logic [1:0]  idx;
  logic signed [15:0] res [3];
  logic        cneg [3];
  logic        out_full;
  fnt_pkg::result_t acc;
  fnt_pkg::result_t obuf;

  assign tri_ready = (state == fnt_pkg::ST_IDLE);
  assign out_valid = out_full;
  assign out_data  = obuf;

  // Magnitudes used by the reduction shift and by the scaler
  logic [32:0] emag [6];
  logic [32:0] emax;
  logic [63:0] mmax;
  always_comb begin
    emag[0] = t.e1x[32] ? 33'(-t.e1x) : t.e1x;
    emag[1] = t.e1y[32] ? 33'(-t.e1y) : t.e1y;
    emag[2] = t.e1z[32] ? 33'(-t.e1z) : t.e1z;
    emag[3] = t.e2x[32] ? 33'(-t.e2x) : t.e2x;
    emag[4] = t.e2y[32] ? 33'(-t.e2y) : t.e2y;
    emag[5] = t.e2z[32] ? 33'(-t.e2z) : t.e2z;
    emax = emag[0];
    for (int i = 1; i < 6; i++) begin
      if (emag[i] > emax) emax = emag[i];
    end
    mmax = m[0];
    if (m[1] > mmax) mmax = m[1];
    if (m[2] > mmax) mmax = m[2];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      fnt_pkg::ST_IDLE:   if (tri_valid) state_next = fnt_pkg::ST_RED;
      fnt_pkg::ST_RED:    state_next = fnt_pkg::ST_CR_A;
      fnt_pkg::ST_CR_A:   state_next = fnt_pkg::ST_CR_B;
      fnt_pkg::ST_CR_B:   state_next = fnt_pkg::ST_CR_C;
      fnt_pkg::ST_CR_C:   state_next = fnt_pkg::ST_DET_A;
      fnt_pkg::ST_DET_A:  state_next = fnt_pkg::ST_DET_B;
      fnt_pkg::ST_DET_B:  state_next = fnt_pkg::ST_TG_A;
      fnt_pkg::ST_TG_A:   state_next = fnt_pkg::ST_TG_B;
      fnt_pkg::ST_TG_B:   state_next = fnt_pkg::ST_TG_C;
      fnt_pkg::ST_TG_C:   state_next = fnt_pkg::ST_U_LOAD;
      fnt_pkg::ST_U_LOAD: state_next = fnt_pkg::ST_U_NORM;
      fnt_pkg::ST_U_NORM: begin
        if (mmax == '0) state_next = fnt_pkg::ST_U_NEXT;
        else if (mmax < 64'd1 << 29 || mmax >= 64'd1 << 30) state_next = fnt_pkg::ST_U_NORM;
        else state_next = fnt_pkg::ST_U_SQ0;
      end
      fnt_pkg::ST_U_SQ0:  state_next = fnt_pkg::ST_U_SQ1;
      fnt_pkg::ST_U_SQ1:  state_next = fnt_pkg::ST_U_SQ2;
      fnt_pkg::ST_U_SQ2:  state_next = fnt_pkg::ST_U_SQRT;
      fnt_pkg::ST_U_SQRT: if (bitv == '0) state_next = fnt_pkg::ST_U_DIV;
      fnt_pkg::ST_U_DIV:  if (dcnt == 7'd0 && idx == 2'd2) state_next = fnt_pkg::ST_U_NEXT;
      fnt_pkg::ST_U_NEXT: state_next = which ? fnt_pkg::ST_OUT : fnt_pkg::ST_U_LOAD;
      fnt_pkg::ST_OUT:    if (!out_full) state_next = fnt_pkg::ST_IDLE;
      default:            state_next = fnt_pkg::ST_IDLE;
    endcase
  end

  // Hold the state register and the output buffer flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fnt_pkg::ST_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (out_full && out_ready) out_full <= 1'b0;
      if (state == fnt_pkg::ST_OUT && !out_full) out_full <= 1'b1;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      fnt_pkg::ST_IDLE: begin
        t <= tri_data;
        which <= 1'b0;
      end
      fnt_pkg::ST_RED: begin
        // Common reduction shift keeps the cross product in range
        for (int i = 0; i < 3; i++) begin
          logic [1:0] s;
          s = (emax >= 33'd1 << 31) ? 2'd2 : (emax >= 33'd1 << 30) ? 2'd1 : 2'd0;
          r1[i] <= (t.e1x[32] && i == 0 || t.e1y[32] && i == 1 ||
                   t.e1z[32] && i == 2) ? 33'(-(emag[i] >> s)) : 33'(emag[i] >> s);
          r2[i] <= (t.e2x[32] && i == 0 || t.e2y[32] && i == 1 ||
                   t.e2z[32] && i == 2) ? 33'(-(emag[i+3] >> s)) : 33'(emag[i+3] >> s);
        end
      end
      fnt_pkg::ST_CR_A: begin
        pa[0] <= 64'($signed(r2[1][31:0]) * $signed(r1[2][31:0]));
        pb[0] <= 64'($signed(r2[2][31:0]) * $signed(r1[1][31:0]));
      end
      fnt_pkg::ST_CR_B: begin
        pa[1] <= 64'($signed(r2[2][31:0]) * $signed(r1[0][31:0]));
        pb[1] <= 64'($signed(r2[0][31:0]) * $signed(r1[2][31:0]));
        pa[2] <= 64'($signed(r2[0][31:0]) * $signed(r1[1][31:0]));
        pb[2] <= 64'($signed(r2[1][31:0]) * $signed(r1[0][31:0]));
      end
      fnt_pkg::ST_CR_C: begin
        for (int i = 0; i < 3; i++) cr[i] <= pa[i] - pb[i];
      end
      fnt_pkg::ST_DET_A: begin
        dpa <= 42'(t.d1v * t.d2u);
        det <= 42'(t.d1u * t.d2v);
      end
      fnt_pkg::ST_DET_B: begin
        det <= dpa - det;
      end
      fnt_pkg::ST_TG_A: begin
        pa[0] <= 64'(t.e1x * -64'(t.d2v));
        pa[1] <= 64'(t.e1y * -64'(t.d2v));
        pa[2] <= 64'(t.e1z * -64'(t.d2v));
      end
      fnt_pkg::ST_TG_B: begin
        pb[0] <= 64'(t.e2x * 64'(t.d1v));
        pb[1] <= 64'(t.e2y * 64'(t.d1v));
        pb[2] <= 64'(t.e2z * 64'(t.d1v));
      end
      fnt_pkg::ST_TG_C: begin
        for (int i = 0; i < 3; i++) begin
          tg[i] <= (det == '0) ? '0 : det[41] ? -(pa[i] + pb[i]) : (pa[i] + pb[i]);
        end
      end
      fnt_pkg::ST_U_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          logic signed [63:0] c;
          c = which ? tg[i] : cr[i];
          cneg[i] <= c[63];
          m[i] <= c[63] ? 64'(-c) : 64'(c);
          res[i] <= '0;
        end
      end
      fnt_pkg::ST_U_NORM: begin
        if (mmax >= 64'd1 << 30) begin
          for (int i = 0; i < 3; i++) m[i] <= m[i] >> 1;
        end else if (mmax != '0 && mmax < 64'd1 << 29) begin
          for (int i = 0; i < 3; i++) m[i] <= m[i] << 1;
        end
      end
      fnt_pkg::ST_U_SQ0: begin
        sq[0] <= m[0][31:0] * m[0][31:0];
        sq[1] <= m[1][31:0] * m[1][31:0];
      end
      fnt_pkg::ST_U_SQ1: begin
        sq[2] <= m[2][31:0] * m[2][31:0];
      end
      fnt_pkg::ST_U_SQ2: begin
        rem <= sq[0] + sq[1] + sq[2];
        root <= '0;
        bitv <= 64'd1 << 62;
      end
      fnt_pkg::ST_U_SQRT: begin
        // One root bit per cycle
        if (bitv != '0) begin
          if (rem >= root + bitv) begin
            rem <= rem - (root + bitv);
            root <= (root >> 1) + bitv;
          end else begin
            root <= root >> 1;
          end
          bitv <= bitv >> 2;
        end else begin
          idx <= 2'd0;
          dsor <= root;
          num <= m[0] * fnt_pkg::ONE_Q14 + (root >> 1);
          quo <= '0;
          rem <= '0;
          dcnt <= 7'd63;
        end
      end
      fnt_pkg::ST_U_DIV: begin
        // Restoring division, one quotient bit per cycle
        logic [64:0] tr;
        logic [63:0] qn;
        logic [63:0] rn;
        tr = {rem, num[dcnt[5:0]]};
        if (tr >= {1'b0, dsor}) begin
          rn = 64'(tr - {1'b0, dsor});
          qn = quo | (64'd1 << dcnt[5:0]);
        end else begin
          rn = tr[63:0];
          qn = quo;
        end
        if (dcnt == 7'd0) begin
          res[idx] <= cneg[idx] ? -16'(qn) : 16'(qn);
          rem <= '0;
          quo <= '0;
          dcnt <= 7'd63;
          if (idx != 2'd2) begin
            idx <= idx + 2'd1;
            num <= m[idx + 2'd1] * fnt_pkg::ONE_Q14 + (dsor >> 1);
          end
        end else begin
          rem <= rn;
          quo <= qn;
          dcnt <= dcnt - 7'd1;
        end
      end
      fnt_pkg::ST_U_NEXT: begin
        if (!which) begin
          acc.normal_x <= res[0];
          acc.normal_y <= res[1];
          acc.normal_z <= res[2];
          acc.normal_valid <= mmax != '0;
        end else begin
          acc.tangent_x <= res[0];
          acc.tangent_y <= res[1];
          acc.tangent_z <= res[2];
          acc.tangent_valid <= mmax != '0;
        end
        which <= 1'b1;
      end
      fnt_pkg::ST_OUT: begin
        // Move the finished word into the output register once it is free
        if (!out_full) obuf <= acc;
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/face_normal_tangent.sv */
// Top level of the face normal and tangent block.
// Depends on fnt_pkg, fnt_front, fnt_queue and fnt_back.
//
// Corners are taken one word per cycle while in_ready is high; every third
// corner completes a triangle whose edges enter a short queue. The back end
// works one triangle at a time: cross product and tangent multiplies, then for
// each of the two vectors a range shift, squaring, a square root and three
// 64-bit restoring divisions in one shared scaler; a zero vector skips them.
// A finished result waits in the output register while the receiver stalls;
// once the queue also holds two triangles, the third corner of the next one is
// held off.
module face_normal_tangent #(
  parameter int QUEUE_DEPTH = fnt_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  fnt_pkg::corner_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output fnt_pkg::result_t out_data
);

  logic          fq_valid, fq_ready, qb_valid, qb_ready;
  fnt_pkg::tri_t fq_data, qb_data;

  fnt_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .tri_valid(fq_valid), .tri_ready(fq_ready), .tri_data(fq_data)
  );

  fnt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
  );

  fnt_back u_back (
    .clk, .rst,
    .tri_valid(qb_valid), .tri_ready(qb_ready), .tri_data(qb_data),
    .out_valid, .out_ready, .out_data
  );

endmodule

/* hw/rtl/fnt_checker.sv */
// Port-level checks for the face normal and tangent block.
// Depends on fnt_pkg; bound to face_normal_tangent.
module fnt_props (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input fnt_pkg::result_t out_data
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Keep the result side empty right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result right after reset");

  // Drive a known ready while a corner is offered
  a_in_ready_known: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> !$isunknown(in_ready))
    else $error("input ready unknown");

  // Invalid normal reads as zero
  a_norm_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.normal_valid |-> out_data.normal_x == 0 &&
    out_data.normal_y == 0 && out_data.normal_z == 0)
    else $error("invalid normal not zero");

  // Invalid tangent reads as zero
  a_tan_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.tangent_valid |-> out_data.tangent_x == 0 &&
    out_data.tangent_y == 0 && out_data.tangent_z == 0)
    else $error("invalid tangent not zero");

endmodule

bind face_normal_tangent fnt_props u_fnt_props (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
